// ----- sv/ivs_pkg.sv -----
package ivs_pkg;

  localparam int POS_W = 16;
  localparam int VAL_W = 32;
  localparam int CNT_W = 9;

  localparam logic [1:0] REQ_PUSH    = 2'd0;
  localparam logic [1:0] REQ_POP     = 2'd1;
  localparam logic [1:0] REQ_INSERT  = 2'd2;
  localparam logic [1:0] REQ_REPLACE = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  typedef struct packed {
    logic [1:0]              req_type;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] item_value;
  } ivs_in_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] read_value;
    logic [1:0]              status;
    logic [CNT_W-1:0]        fill_count;
  } ivs_out_t;

  typedef struct packed {
    logic             load;
    logic [POS_W-1:0] wpos;
    logic             shift;
    logic [POS_W-1:0] lo;
    logic [POS_W-1:0] hi;
    logic             top_en;
    logic [POS_W-1:0] top_pos;
  } ivs_cmd_t;

endpackage

// ----- sv/ivs_cell.sv -----
module ivs_cell #(
  parameter int IDX = 0
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ivs_pkg::ivs_cmd_t             cmd,
  input  logic [ivs_pkg::VAL_W-1:0]     item,
  input  logic [ivs_pkg::VAL_W-1:0]     prev_entry,
  output logic [ivs_pkg::VAL_W-1:0]     entry,
  output logic [ivs_pkg::VAL_W-1:0]     tap
);

  localparam logic [ivs_pkg::POS_W-1:0] ME = ivs_pkg::POS_W'(IDX);

  logic [ivs_pkg::VAL_W-1:0] entry_r;
  logic [ivs_pkg::VAL_W-1:0] entry_nxt;

  always_comb begin
    entry_nxt = entry_r;
    priority if (cmd.load && cmd.wpos == ME) begin
      entry_nxt = item;
    end else if (cmd.shift && ME > cmd.lo && ME <= cmd.hi) begin
      entry_nxt = prev_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r <= '0;
    end else begin
      entry_r <= entry_nxt;
    end
  end

  assign entry = entry_r;
  assign tap   = (cmd.top_en && cmd.top_pos == ME) ? entry_r : '0;

endmodule

// ----- sv/ivs_tree.sv -----
module ivs_tree #(
  parameter int DEPTH = 256
) (
  input  logic                      clk,
  input  logic [ivs_pkg::VAL_W-1:0] taps [DEPTH],
  output logic [ivs_pkg::VAL_W-1:0] root
);

  localparam int LVL = $clog2(DEPTH);
  localparam int N   = 1 << LVL;

  logic [ivs_pkg::VAL_W-1:0] leaf   [N];
  logic [ivs_pkg::VAL_W-1:0] node_r [1:N-1];

  genvar j;
  generate
    for (j = 0; j < N; j++) begin : g_leaf
      if (j < DEPTH) begin : g_used
        assign leaf[j] = taps[j];
      end else begin : g_pad
        assign leaf[j] = '0;
      end
    end

    for (j = 1; j < N; j++) begin : g_node
      if (2 * j >= N) begin : g_bottom
        always_ff @(posedge clk) begin
          node_r[j] <= leaf[2*j-N] | leaf[2*j+1-N];
        end
      end else begin : g_inner
        always_ff @(posedge clk) begin
          node_r[j] <= node_r[2*j] | node_r[2*j+1];
        end
      end
    end
  endgenerate

  assign root = node_r[1];

endmodule

// ----- sv/indexed_vector_store.sv -----
// Channel  Direction  Handshake           Payload
// in_      input      in_valid/in_stall   ivs_pkg::ivs_in_t
// out_     output     out_valid/out_stall ivs_pkg::ivs_out_t
// cfg_     input      cfg_we              cfg_wdata (empty marker)
//
// A new transfer is not taken until the registered OR tree that finds the
// last entry has settled after each update of the cell row. The result is
// registered and appears in the cycle after its transfer.
// Synchronous active-low reset clears every cell, the count and the marker.
// The output register holds a result while out_stall is high; input stalls then.
module indexed_vector_store #(
  parameter int DEPTH = 256
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  ivs_pkg::ivs_in_t          in_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output ivs_pkg::ivs_out_t         out_data,
  input  logic                      cfg_we,
  input  logic [ivs_pkg::VAL_W-1:0] cfg_wdata
);

  localparam int UW       = $clog2(DEPTH + 1);
  localparam int TREE_LAT = $clog2(DEPTH);
  localparam int WAIT_W   = $clog2(TREE_LAT + 1);
  localparam logic [ivs_pkg::POS_W-1:0] DEPTH_P = ivs_pkg::POS_W'(DEPTH);

  logic [UW-1:0]             used_r;
  logic [UW-1:0]             used_nxt;
  logic [WAIT_W-1:0]         wait_r;
  logic [ivs_pkg::VAL_W-1:0] marker_r;
  logic                      out_valid_r;
  ivs_pkg::ivs_out_t         out_data_r;
  ivs_pkg::ivs_out_t         res;
  ivs_pkg::ivs_cmd_t         cmd;
  logic                      accept;
  logic                      load;
  logic                      shift;
  logic [ivs_pkg::POS_W-1:0] wpos;
  logic [ivs_pkg::POS_W-1:0] used16;
  logic [ivs_pkg::POS_W-1:0] pos;
  logic [ivs_pkg::VAL_W-1:0] root;
  logic [ivs_pkg::VAL_W-1:0] ent  [DEPTH];
  logic [ivs_pkg::VAL_W-1:0] taps [DEPTH];

  assign in_stall = (wait_r != '0) || (out_valid_r && out_stall);
  assign accept   = in_valid && !in_stall;
  assign used16   = ivs_pkg::POS_W'(used_r);
  assign pos      = in_data.position;

  always_comb begin
    used_nxt       = used_r;
    load           = 1'b0;
    shift          = 1'b0;
    wpos           = pos;
    res.read_value = '0;
    res.status     = ivs_pkg::ST_OK;
    unique case (in_data.req_type)
      ivs_pkg::REQ_PUSH: begin
        if (used16 == DEPTH_P) begin
          res.status = ivs_pkg::ST_FULL;
        end else begin
          load     = 1'b1;
          wpos     = used16;
          used_nxt = used_r + UW'(1);
        end
      end
      ivs_pkg::REQ_POP: begin
        if (used_r == '0) begin
          res.read_value = marker_r;
          res.status     = ivs_pkg::ST_EMPTY;
        end else begin
          res.read_value = root;
          used_nxt       = used_r - UW'(1);
        end
      end
      ivs_pkg::REQ_INSERT: begin
        priority if (pos >= DEPTH_P) begin
          res.status = ivs_pkg::ST_RANGE;
        end else if (pos >= used16) begin
          load     = 1'b1;
          used_nxt = UW'(pos + ivs_pkg::POS_W'(1));
        end else if (used16 == DEPTH_P) begin
          res.status = ivs_pkg::ST_FULL;
        end else begin
          load     = 1'b1;
          shift    = 1'b1;
          used_nxt = used_r + UW'(1);
        end
      end
      ivs_pkg::REQ_REPLACE: begin
        if (pos >= DEPTH_P) begin
          res.status = ivs_pkg::ST_RANGE;
        end else begin
          load = 1'b1;
          if (pos >= used16) begin
            used_nxt = UW'(pos + ivs_pkg::POS_W'(1));
          end
        end
      end
      default: begin
        res.status = ivs_pkg::ST_OK;
      end
    endcase
    res.fill_count = ivs_pkg::CNT_W'(used_nxt);
  end

  assign cmd.load    = accept && load;
  assign cmd.wpos    = wpos;
  assign cmd.shift   = accept && shift;
  assign cmd.lo      = pos;
  assign cmd.hi      = used16;
  assign cmd.top_en  = used_r != '0;
  assign cmd.top_pos = used16 - ivs_pkg::POS_W'(1);

  genvar i;
  generate
    for (i = 0; i < DEPTH; i++) begin : g_cell
      if (i == 0) begin : g_first
        ivs_cell #(.IDX(i)) u_cell (
          .clk        (clk),
          .rst_n      (rst_n),
          .cmd        (cmd),
          .item       (in_data.item_value),
          .prev_entry ({ivs_pkg::VAL_W{1'b0}}),
          .entry      (ent[i]),
          .tap        (taps[i])
        );
      end else begin : g_next
        ivs_cell #(.IDX(i)) u_cell (
          .clk        (clk),
          .rst_n      (rst_n),
          .cmd        (cmd),
          .item       (in_data.item_value),
          .prev_entry (ent[i-1]),
          .entry      (ent[i]),
          .tap        (taps[i])
        );
      end
    end
  endgenerate

  ivs_tree #(.DEPTH(DEPTH)) u_tree (
    .clk  (clk),
    .taps (taps),
    .root (root)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r      <= '0;
      wait_r      <= WAIT_W'(TREE_LAT);
      marker_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        marker_r <= cfg_wdata;
      end
      if (accept) begin
        used_r      <= used_nxt;
        wait_r      <= WAIT_W'(TREE_LAT);
        out_valid_r <= 1'b1;
      end else begin
        if (wait_r != '0) begin
          wait_r <= wait_r - WAIT_W'(1);
        end
        if (out_valid_r && !out_stall) begin
          out_valid_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
